/* sv/ycc_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, register codes and the floor-shift/saturate function
// for the YCbCr color matrix converter. No dependencies.
package ycc_pkg;

  localparam int LUMA_LANES = 4;     // luma lanes built, 1..4
  localparam int SAMPLE_W   = 8;
  localparam int COEF_W     = 18;    // Q16 two's complement coefficient
  localparam int CTR_W      = 9;     // centered chroma / floored luma
  localparam int PROD_W     = COEF_W + CTR_W - 1;
  localparam int SUM_W      = 28;    // two products plus bias
  localparam int LUMA_W     = 30;    // shared sum plus luma term
  localparam int FRAC_W     = 16;
  localparam int ITEM_W     = 6 * SAMPLE_W;
  localparam int ADDR_W     = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [SUM_W-1:0] LUMA_BIAS   = SUM_W'(1081344);
  localparam logic [SUM_W-1:0] CHROMA_BIAS = SUM_W'(8421376);
  localparam logic [SAMPLE_W:0] CHROMA_MID = (SAMPLE_W+1)'(128);
  localparam logic [SAMPLE_W:0] LUMA_FLOOR = (SAMPLE_W+1)'(16);

  localparam logic signed [COEF_W-1:0] COEF_ZERO  = '0;
  localparam logic signed [COEF_W-1:0] COEF_UNITY = COEF_W'(65536);

  // register indexes, byte address is 4 * index
  localparam logic [REG_IDX_W-1:0] REG_LUMA_FROM_U = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LUMA_FROM_V = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_U_FROM_U    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_U_FROM_V    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_V_FROM_U    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_V_FROM_V    = 3'd5;

  // floor divide by 2^16, then saturate to 0..255
  function automatic logic [SAMPLE_W-1:0] floor_clip8(input logic signed [LUMA_W-1:0] x);
    logic signed [LUMA_W-FRAC_W-1:0] q;
    logic [SAMPLE_W-1:0] res;
    q = x[LUMA_W-1:FRAC_W];
    if (q < 0) begin
      res = '0;
    end else if (q > (LUMA_W-FRAC_W)'(255)) begin
      res = '1;
    end else begin
      res = q[SAMPLE_W-1:0];
    end
    return res;
  endfunction

endpackage

/* sv/ycc_mac.sv */
`timescale 1ns / 1ps
// Two-tap multiply-accumulate: coef_a*u + coef_b*v + bias over two stages.
// Depends on ycc_pkg.
module ycc_mac
  import ycc_pkg::*;
(
  input  logic                     clk,
  input  logic                     en1,
  input  logic                     en2,
  input  logic signed [COEF_W-1:0] coef_a,
  input  logic signed [COEF_W-1:0] coef_b,
  input  logic signed [CTR_W-1:0]  u,
  input  logic signed [CTR_W-1:0]  v,
  input  logic        [SUM_W-1:0]  bias,
  output logic signed [SUM_W-1:0]  sum
);

  logic signed [PROD_W-1:0] prod_a_r, prod_b_r;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;

  // products are registered before the add
  always_ff @(posedge clk) begin
    if (en1) begin
      prod_a_r <= PROD_W'(coef_a * u);
      prod_b_r <= PROD_W'(coef_b * v);
    end
    if (en2) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum_nxt = SUM_W'(prod_a_r) + SUM_W'(prod_b_r) + $signed(bias);
  assign sum     = sum_r;

endmodule

/* sv/ycc_lane.sv */
`timescale 1ns / 1ps
// One luma lane: add the luma term to the shared chroma sum, floor-shift,
// saturate and register. Depends on ycc_pkg.
module ycc_lane
  import ycc_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic [SAMPLE_W-1:0]     luma,
  input  logic signed [SUM_W-1:0] shared,
  output logic [SAMPLE_W-1:0]     luma_out
);

  logic signed [CTR_W-1:0]  y_ofs;
  logic signed [LUMA_W-1:0] acc;
  logic [SAMPLE_W-1:0]      luma_out_r;

  assign y_ofs = $signed({1'b0, luma} - LUMA_FLOOR);
  assign acc   = (LUMA_W'(y_ofs) <<< FRAC_W) + LUMA_W'(shared);

  always_ff @(posedge clk) begin
    if (en) begin
      luma_out_r <= floor_clip8(acc);
    end
  end

  assign luma_out = luma_out_r;

endmodule

/* sv/ycbcr_color_matrix_convert.sv */
`timescale 1ns / 1ps
// Top level of the YCbCr color matrix converter: stream ports, APB
// coefficient registers, pipeline control. Depends on ycc_pkg, ycc_mac, ycc_lane.

// One item (a Cb/Cr pair and four luma samples) is accepted every clock
// while the output side keeps up; a result passes three register stages,
// the first one loaded at the accepting edge, before it is offered on the
// output. The rate is set by the six 18x9 coefficient multipliers, one per
// chroma tap, which each take a new pair every cycle while stage 1 loads:
// stage 1 forms the products, stage 2 sums them with the bias (one shared
// sum feeds all luma lanes), stage 3 has the luma lanes and chroma paths
// floor-shift by 16 and saturate into the output register. Each stage
// holds only when the one after it is full and stalled, so a waiting
// result does not block new requests while a bubble remains. Coefficients
// sit at byte addresses 0x00..0x14 in the order luma-from-U, luma-from-V,
// U-from-U, U-from-V, V-from-U, V-from-V; write them only while idle.
// Luma lanes beyond LUMA_LANES are driven as zero on the output.
module ycbcr_color_matrix_convert
  import ycc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // stream input
  input  logic              in_tvalid,
  output logic              in_tready,
  // luma_0, luma_1, luma_2, luma_3, chroma_u, chroma_v (8 bits each)
  input  logic [ITEM_W-1:0] in_tdata,
  // stream output
  output logic              out_tvalid,
  input  logic              out_tready,
  // out_luma_0..3, out_chroma_u, out_chroma_v (8 bits each)
  output logic [ITEM_W-1:0] out_tdata,
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  // ---------------- coefficient registers ----------------
  logic signed [COEF_W-1:0] c_lu_r, c_lv_r, c_uu_r, c_uv_r, c_vu_r, c_vv_r;
  logic                     cfg_wr;
  logic [REG_IDX_W-1:0]     cfg_idx;
  logic signed [COEF_W-1:0] cfg_rd_coef;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_lu_r <= COEF_ZERO;
      c_lv_r <= COEF_ZERO;
      c_uu_r <= COEF_UNITY;
      c_uv_r <= COEF_ZERO;
      c_vu_r <= COEF_ZERO;
      c_vv_r <= COEF_UNITY;
    end else if (cfg_wr) begin
      // bits above the sign bit are dropped; unknown indexes are ignored
      case (cfg_idx)
        REG_LUMA_FROM_U: c_lu_r <= cfg_pwdata[COEF_W-1:0];
        REG_LUMA_FROM_V: c_lv_r <= cfg_pwdata[COEF_W-1:0];
        REG_U_FROM_U:    c_uu_r <= cfg_pwdata[COEF_W-1:0];
        REG_U_FROM_V:    c_uv_r <= cfg_pwdata[COEF_W-1:0];
        REG_V_FROM_U:    c_vu_r <= cfg_pwdata[COEF_W-1:0];
        REG_V_FROM_V:    c_vv_r <= cfg_pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LUMA_FROM_U: cfg_rd_coef = c_lu_r;
      REG_LUMA_FROM_V: cfg_rd_coef = c_lv_r;
      REG_U_FROM_U:    cfg_rd_coef = c_uu_r;
      REG_U_FROM_V:    cfg_rd_coef = c_uv_r;
      REG_V_FROM_U:    cfg_rd_coef = c_vu_r;
      REG_V_FROM_V:    cfg_rd_coef = c_vv_r;
      default:         cfg_rd_coef = COEF_ZERO;
    endcase
  end

  assign cfg_prdata = 32'(cfg_rd_coef);

  // ---------------- pipeline control ----------------
  logic s1_v_r, s1_v_nxt, s2_v_r, s2_v_nxt, out_v_r, out_v_nxt;
  logic en1, en2, en3;

  // a stage loads when it is empty or its contents move on
  assign en3       = !out_v_r || out_tready;
  assign en2       = !s2_v_r || en3;
  assign en1       = !s1_v_r || en2;
  assign in_tready = en1;

  assign s1_v_nxt  = en1 ? in_tvalid : s1_v_r;
  assign s2_v_nxt  = en2 ? s1_v_r    : s2_v_r;
  assign out_v_nxt = en3 ? s2_v_r    : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  assign out_tvalid = out_v_r;

  // ---------------- chroma and shared luma sums ----------------
  logic signed [CTR_W-1:0] u_ctr, v_ctr;
  logic signed [SUM_W-1:0] luma_sum, u_sum, v_sum;

  // re-center chroma around zero
  assign u_ctr = $signed({1'b0, in_tdata[4*SAMPLE_W +: SAMPLE_W]} - CHROMA_MID);
  assign v_ctr = $signed({1'b0, in_tdata[5*SAMPLE_W +: SAMPLE_W]} - CHROMA_MID);

  ycc_mac u_mac_luma (
    .clk(clk), .en1(en1), .en2(en2), .coef_a(c_lu_r), .coef_b(c_lv_r),
    .u(u_ctr), .v(v_ctr), .bias(LUMA_BIAS), .sum(luma_sum)
  );

  ycc_mac u_mac_u (
    .clk(clk), .en1(en1), .en2(en2), .coef_a(c_uu_r), .coef_b(c_uv_r),
    .u(u_ctr), .v(v_ctr), .bias(CHROMA_BIAS), .sum(u_sum)
  );

  ycc_mac u_mac_v (
    .clk(clk), .en1(en1), .en2(en2), .coef_a(c_vu_r), .coef_b(c_vv_r),
    .u(u_ctr), .v(v_ctr), .bias(CHROMA_BIAS), .sum(v_sum)
  );

  // ---------------- luma lanes ----------------
  logic [SAMPLE_W-1:0] y_s1_r [LUMA_LANES];
  logic [SAMPLE_W-1:0] y_s2_r [LUMA_LANES];
  logic [SAMPLE_W-1:0] y_out  [4];

  // carry the luma samples alongside the chroma products
  always_ff @(posedge clk) begin
    for (int k = 0; k < LUMA_LANES; k++) begin
      if (en1) y_s1_r[k] <= in_tdata[k*SAMPLE_W +: SAMPLE_W];
      if (en2) y_s2_r[k] <= y_s1_r[k];
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    if (k < LUMA_LANES) begin : g_on
      ycc_lane u_lane (
        .clk(clk), .en(en3), .luma(y_s2_r[k]), .shared(luma_sum),
        .luma_out(y_out[k])
      );
    end else begin : g_off
      assign y_out[k] = '0;
    end
  end

  // ---------------- chroma outputs and merge ----------------
  logic [SAMPLE_W-1:0] cb_out_r, cr_out_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      cb_out_r <= floor_clip8(LUMA_W'(u_sum));
      cr_out_r <= floor_clip8(LUMA_W'(v_sum));
    end
  end

  assign out_tdata = {cr_out_r, cb_out_r, y_out[3], y_out[2], y_out[1], y_out[0]};

endmodule
